// ===== rtl/cck_pkg.sv =====
// ----------------------------------------------------------------------------
// cck_pkg: calendar clock shared types and constants
// operation codes, request/response/state records and month length lookup
// ----------------------------------------------------------------------------
package cck_pkg;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_SET_DATE = 2'd1,
    OP_SET_TIME = 2'd2,
    OP_POLL     = 2'd3
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] new_year;
    logic [7:0]  new_month;
    logic [7:0]  new_day;
    logic [7:0]  new_hour;
    logic [7:0]  new_minute;
    logic [7:0]  new_second;
  } req_t;

  // calendar state, year_mod400 tracks year % 400 for the leap rule
  typedef struct packed {
    logic [15:0] year;
    logic [8:0]  year_mod400;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  milli;
    logic        flag;
  } state_t;

  typedef struct packed {
    logic [15:0] cur_year;
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic [4:0]  cur_hour;
    logic [5:0]  cur_minute;
    logic [5:0]  cur_second;
    logic [9:0]  cur_milli;
    logic        second_changed;
    logic        set_accepted;
  } rsp_t;

  localparam logic [9:0]  MilliLast   = 10'd999;
  localparam logic [5:0]  SecondLast  = 6'd59;
  localparam logic [5:0]  MinuteLast  = 6'd59;
  localparam logic [4:0]  HourLast    = 5'd23;
  localparam logic [3:0]  MonthLast   = 4'd12;
  localparam logic [3:0]  MonthFirst  = 4'd1;
  localparam logic [4:0]  DayFirst    = 5'd1;
  localparam logic [15:0] YearMin     = 16'd2000;
  localparam logic [15:0] YearMax     = 16'd2100;
  localparam logic [15:0] YearTop     = 16'hFFFF;
  localparam logic [8:0]  YearModLast = 9'd399;

  localparam state_t StateReset = '{
    year:        16'd2026,
    year_mod400: 9'd26,
    month:       4'd7,
    day:         5'd11,
    hour:        5'd0,
    minute:      6'd0,
    second:      6'd0,
    milli:       10'd0,
    flag:        1'b0
  };

  function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
    logic [4:0] days;
    case (month)
      4'd2: begin
        days = leap ? 5'd29 : 5'd28;
      end
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: begin
        days = 5'd31;
      end
      default: begin
        days = 5'd30;
      end
    endcase
    return days;
  endfunction

endpackage

// ===== rtl/cck_req_if.sv =====
// ----------------------------------------------------------------------------
// cck_req_if: request channel
// valid/ready handshake carrying one calendar operation
// ----------------------------------------------------------------------------
interface cck_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] new_year;
  logic [7:0]  new_month;
  logic [7:0]  new_day;
  logic [7:0]  new_hour;
  logic [7:0]  new_minute;
  logic [7:0]  new_second;

  modport source (
    output valid, op, new_year, new_month, new_day, new_hour, new_minute, new_second,
    input  ready
  );
  modport sink (
    input  valid, op, new_year, new_month, new_day, new_hour, new_minute, new_second,
    output ready
  );
endinterface

// ===== rtl/cck_rsp_if.sv =====
// ----------------------------------------------------------------------------
// cck_rsp_if: response channel
// valid/ready handshake carrying the date and time after one request
// ----------------------------------------------------------------------------
interface cck_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] cur_year;
  logic [3:0]  cur_month;
  logic [4:0]  cur_day;
  logic [4:0]  cur_hour;
  logic [5:0]  cur_minute;
  logic [5:0]  cur_second;
  logic [9:0]  cur_milli;
  logic        second_changed;
  logic        set_accepted;

  modport source (
    output valid, cur_year, cur_month, cur_day, cur_hour, cur_minute, cur_second,
           cur_milli, second_changed, set_accepted,
    input  ready
  );
  modport sink (
    input  valid, cur_year, cur_month, cur_day, cur_hour, cur_minute, cur_second,
           cur_milli, second_changed, set_accepted,
    output ready
  );
endinterface

// ===== rtl/cck_in_reg.sv =====
// ----------------------------------------------------------------------------
// cck_in_reg: request input register
// captures one request per cycle, frees up when the next stage advances
// ----------------------------------------------------------------------------
module cck_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  cck_req_if.sink       req_i,
  input  logic          adv_i,
  output logic          valid_o,
  output cck_pkg::req_t req_o
);
  import cck_pkg::*;

  logic valid_q;
  req_t req_q;
  logic ready;

  assign ready       = !valid_q || adv_i;
  assign req_i.ready = ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready) begin
      valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready && req_i.valid) begin
      req_q.op         <= op_e'(req_i.op);
      req_q.new_year   <= req_i.new_year;
      req_q.new_month  <= req_i.new_month;
      req_q.new_day    <= req_i.new_day;
      req_q.new_hour   <= req_i.new_hour;
      req_q.new_minute <= req_i.new_minute;
      req_q.new_second <= req_i.new_second;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;
endmodule

// ===== rtl/cck_next.sv =====
// ----------------------------------------------------------------------------
// cck_next: calendar next-state logic
// tick carry chain, set checks, flag poll and response assembly
// ----------------------------------------------------------------------------
module cck_next (
  input  cck_pkg::state_t state_i,
  input  cck_pkg::req_t   req_i,
  output cck_pkg::state_t state_o,
  output cck_pkg::rsp_t   rsp_o
);
  import cck_pkg::*;

  logic       leap;
  logic [4:0] month_days;
  logic       milli_wrap;
  logic       second_wrap;
  logic       minute_wrap;
  logic       hour_wrap;
  logic       day_wrap;
  logic       month_wrap;
  logic       date_ok;
  logic       time_ok;
  logic       changed;
  logic       accepted;
  state_t     nxt;

  // leap: divisible by 4, and not a century unless divisible by 400
  assign leap = (state_i.year[1:0] == 2'b00) &&
                !(state_i.year_mod400 inside {9'd100, 9'd200, 9'd300});
  assign month_days = days_in_month(state_i.month, leap);

  // carry chain of the tick
  assign milli_wrap  = state_i.milli >= MilliLast;
  assign second_wrap = milli_wrap && (state_i.second >= SecondLast);
  assign minute_wrap = second_wrap && (state_i.minute >= MinuteLast);
  assign hour_wrap   = minute_wrap && (state_i.hour >= HourLast);
  assign day_wrap    = hour_wrap && (state_i.day >= month_days);
  assign month_wrap  = day_wrap && (state_i.month >= MonthLast);

  assign date_ok = (req_i.new_year >= YearMin) && (req_i.new_year <= YearMax) &&
                   (req_i.new_month >= 8'd1) && (req_i.new_month <= 8'd12) &&
                   (req_i.new_day >= 8'd1) && (req_i.new_day <= 8'd31);
  assign time_ok = (req_i.new_hour <= 8'd23) && (req_i.new_minute <= 8'd59) &&
                   (req_i.new_second <= 8'd59);

  always_comb begin
    nxt      = state_i;
    changed  = 1'b0;
    accepted = 1'b0;
    case (req_i.op)
      OP_TICK: begin
        nxt.milli = milli_wrap ? 10'd0 : state_i.milli + 10'd1;
        if (milli_wrap) begin
          nxt.flag   = 1'b1;
          nxt.second = second_wrap ? 6'd0 : state_i.second + 6'd1;
        end
        if (second_wrap) begin
          nxt.minute = minute_wrap ? 6'd0 : state_i.minute + 6'd1;
        end
        if (minute_wrap) begin
          nxt.hour = hour_wrap ? 5'd0 : state_i.hour + 5'd1;
        end
        if (hour_wrap) begin
          nxt.day = day_wrap ? DayFirst : state_i.day + 5'd1;
        end
        if (day_wrap) begin
          nxt.month = month_wrap ? MonthFirst : state_i.month + 4'd1;
        end
        if (month_wrap) begin
          nxt.year = state_i.year + 16'd1;
          // 65536 is a multiple of 16 but wraps to year 0, whose residue is 0
          if (state_i.year == YearTop || state_i.year_mod400 >= YearModLast) begin
            nxt.year_mod400 = 9'd0;
          end else begin
            nxt.year_mod400 = state_i.year_mod400 + 9'd1;
          end
        end
      end
      OP_SET_DATE: begin
        if (date_ok) begin
          nxt.year        = req_i.new_year;
          // 2000 is a multiple of 400, so the residue is the offset from it
          nxt.year_mod400 = 9'(req_i.new_year - YearMin);
          nxt.month       = req_i.new_month[3:0];
          nxt.day         = req_i.new_day[4:0];
          accepted        = 1'b1;
        end
      end
      OP_SET_TIME: begin
        if (time_ok) begin
          nxt.hour   = req_i.new_hour[4:0];
          nxt.minute = req_i.new_minute[5:0];
          nxt.second = req_i.new_second[5:0];
          nxt.milli  = 10'd0;
          accepted   = 1'b1;
        end
      end
      OP_POLL: begin
        changed  = state_i.flag;
        nxt.flag = 1'b0;
      end
      default: begin
        nxt = state_i;
      end
    endcase
  end

  assign state_o = nxt;

  assign rsp_o.cur_year       = nxt.year;
  assign rsp_o.cur_month      = nxt.month;
  assign rsp_o.cur_day        = nxt.day;
  assign rsp_o.cur_hour       = nxt.hour;
  assign rsp_o.cur_minute     = nxt.minute;
  assign rsp_o.cur_second     = nxt.second;
  assign rsp_o.cur_milli      = nxt.milli;
  assign rsp_o.second_changed = changed;
  assign rsp_o.set_accepted   = accepted;
endmodule

// ===== rtl/calendar_clock_ms_tick_top.sv =====
// ----------------------------------------------------------------------------
// calendar_clock_ms_tick_top: millisecond-driven calendar clock
// date and time of day with Gregorian leap years, set and poll requests
// ----------------------------------------------------------------------------
// Each request (tick one millisecond, set date, set time, poll) returns one
// response holding the full date and time after the request, plus the sticky
// second-rollover flag on a poll and the set check outcome on a set. A request
// is captured in an input register, and once the response register is empty
// or being drained, the carry chain and set checks update the calendar state
// and load the response register; one request is taken every cycle while the
// output does not stall, so the throughput is one request per clock. The
// response is offered from the response register, which follows the input
// register. The input register keeps taking requests while a response waits
// on a stalled output, until both registers are full.
// Rejected sets leave the state untouched; the year wraps from 65535 to 0.
// ----------------------------------------------------------------------------
module calendar_clock_ms_tick_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  cck_req_if.sink   req_i,
  cck_rsp_if.source rsp_o
);
  import cck_pkg::*;

  // input stage
  logic   s1_valid;
  req_t   s1_req;

  // advance when the response register is empty or being drained
  logic   adv;
  logic   fire;

  // calendar state and response register
  state_t state_q;
  state_t state_d;
  rsp_t   rsp_d;
  rsp_t   rsp_q;
  logic   out_valid_q;

  assign adv  = !out_valid_q || rsp_o.ready;
  assign fire = s1_valid && adv;

  cck_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .adv_i   (adv),
    .valid_o (s1_valid),
    .req_o   (s1_req)
  );

  cck_next u_next (
    .state_i (state_q),
    .req_i   (s1_req),
    .state_o (state_d),
    .rsp_o   (rsp_d)
  );

  // state commits only when the response for the request is loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateReset;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        state_q <= state_d;
      end
      if (adv) begin
        out_valid_q <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rsp_q <= rsp_d;
    end
  end

  // response port
  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.cur_year       = rsp_q.cur_year;
  assign rsp_o.cur_month      = rsp_q.cur_month;
  assign rsp_o.cur_day        = rsp_q.cur_day;
  assign rsp_o.cur_hour       = rsp_q.cur_hour;
  assign rsp_o.cur_minute     = rsp_q.cur_minute;
  assign rsp_o.cur_second     = rsp_q.cur_second;
  assign rsp_o.cur_milli      = rsp_q.cur_milli;
  assign rsp_o.second_changed = rsp_q.second_changed;
  assign rsp_o.set_accepted   = rsp_q.set_accepted;
endmodule

// ===== rtl/cck_checker.sv =====
// ----------------------------------------------------------------------------
// cck_checker: response port checks
// ranges of the reported date and time and response stability under stall
// ----------------------------------------------------------------------------
module cck_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        ready_i,
  input logic [15:0] cur_year_i,
  input logic [3:0]  cur_month_i,
  input logic [4:0]  cur_day_i,
  input logic [4:0]  cur_hour_i,
  input logic [5:0]  cur_minute_i,
  input logic [5:0]  cur_second_i,
  input logic [9:0]  cur_milli_i,
  input logic        second_changed_i,
  input logic        set_accepted_i
);

  // stalled response holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(cur_year_i) && $stable(cur_milli_i) &&
      $stable(cur_second_i) && $stable(second_changed_i) && $stable(set_accepted_i))
    else $error("response changed while stalled");

  // time of day stays in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> cur_milli_i <= 10'd999 && cur_second_i <= 6'd59 &&
      cur_minute_i <= 6'd59 && cur_hour_i <= 5'd23)
    else $error("time of day out of range");

  // month and day stay in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> cur_month_i >= 4'd1 && cur_month_i <= 4'd12 && cur_day_i >= 5'd1)
    else $error("date out of range");

  // a set never reports the rollover flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && set_accepted_i |-> !second_changed_i)
    else $error("set response carries rollover flag");

endmodule

bind calendar_clock_ms_tick_top cck_checker u_cck_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .valid_i          (rsp_o.valid),
  .ready_i          (rsp_o.ready),
  .cur_year_i       (rsp_o.cur_year),
  .cur_month_i      (rsp_o.cur_month),
  .cur_day_i        (rsp_o.cur_day),
  .cur_hour_i       (rsp_o.cur_hour),
  .cur_minute_i     (rsp_o.cur_minute),
  .cur_second_i     (rsp_o.cur_second),
  .cur_milli_i      (rsp_o.cur_milli),
  .second_changed_i (rsp_o.second_changed),
  .set_accepted_i   (rsp_o.set_accepted)
);
